// ----- hdl/cmsd_pkg.sv -----
// Carry motion streak detector: shared types and constants.
// Word structs, event codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package cmsd_pkg;

  typedef enum logic [1:0] {
    OP_PULSE  = 2'd0,
    OP_CHECK  = 2'd1,
    OP_SETTLE = 2'd2,
    OP_KEY    = 2'd3
  } cmsd_op_e;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DurW     = 32;
  localparam int unsigned GapW     = 16;
  localparam int unsigned NowW     = 32;

  localparam logic [CfgIdxW-1:0] CFG_CARRY_EN  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_CARRY_DUR = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_STILL_EN  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_STEP_GAP  = CfgIdxW'(3);

  localparam logic [DurW-1:0] CARRY_DUR_RST = DurW'(60000);
  localparam logic [GapW-1:0] STEP_GAP_RST  = GapW'(2000);

  typedef struct packed {
    cmsd_op_e        op;
    logic [NowW-1:0] now_ms;
  } cmsd_in_t;

  typedef struct packed {
    logic carrying;
    logic state_changed;
    logic force_sleep;
    logic wake_disabled;
  } cmsd_out_t;

  typedef struct packed {
    logic            carry_enabled;
    logic [DurW-1:0] carry_duration_ms;
    logic            still_wake_enabled;
    logic [GapW-1:0] step_gap_ms;
  } cmsd_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/carry_motion_streak_detector.sv -----
// Carry motion streak detector: top level.
// Input register, evaluation core and result register; uses cmsd_pkg,
// cmsd_cfg_regs and cmsd_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one event word:
//   op (pulse, check, settle, key press) and the current uptime now_ms.
//   Output channel (out_valid_o/out_ready_i/out_item_o) returns exactly one
//   result word per event, in order: carrying, state_changed,
//   force_sleep and wake_disabled.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes register
//   cfg_index_i: 0 carry enable, 1 carry duration, 2 still-wake enable,
//   3 step gap. Other indexes are ignored. Write only while no event is
//   in flight.
//   An accepted word moves from the input register into the result one
//   when that is empty or being read; one event per cycle is sustained
//   while out_ready_i stays high. The streak state updates on that move.
//   Reset clears the streak, arms the settle check and loads the register
//   defaults. When the receiver stalls, the held result stays and one more
//   event is accepted into the input register; then in_ready_o drops.
`default_nettype none

module carry_motion_streak_detector
  import cmsd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire cmsd_in_t            in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output cmsd_out_t                out_item_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cmsd_cfg_t cfg;
  cmsd_out_t result;

  logic      in_vld_q;
  cmsd_in_t  in_item_q;
  logic      out_vld_q;
  cmsd_out_t out_item_q;
  logic      advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_vld_q || out_ready_i;
  assign in_ready_o  = !in_vld_q || advance;

  cmsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cmsd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_vld_q && advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (advance && in_vld_q) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- hdl/cmsd_cfg_regs.sv -----
// Carry motion streak detector: configuration register file.
// Decodes writes on the configuration channel; uses cmsd_pkg.
`default_nettype none

module cmsd_cfg_regs
  import cmsd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cmsd_cfg_t                cfg_o
);

  cmsd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CARRY_EN:  cfg_d.carry_enabled      = cfg_data_i[0];
        CFG_CARRY_DUR: cfg_d.carry_duration_ms  = cfg_data_i[DurW-1:0];
        CFG_STILL_EN:  cfg_d.still_wake_enabled = cfg_data_i[0];
        CFG_STEP_GAP:  cfg_d.step_gap_ms        = cfg_data_i[GapW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.carry_enabled      <= 1'b1;
      cfg_q.carry_duration_ms  <= CARRY_DUR_RST;
      cfg_q.still_wake_enabled <= 1'b1;
      cfg_q.step_gap_ms        <= STEP_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/cmsd_core.sv -----
// Carry motion streak detector: streak state and event evaluation.
// Holds the streak registers and builds one result word per event; uses cmsd_pkg.
`default_nettype none

module cmsd_core
  import cmsd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire cmsd_in_t  item_i,
  input  wire cmsd_cfg_t cfg_i,
  output cmsd_out_t      result_o
);

  localparam int unsigned CmpW = (TIME_BITS > DurW) ? TIME_BITS : DurW;

  logic                 streak_valid_q, streak_valid_d;
  logic [TIME_BITS-1:0] streak_begin_q, streak_begin_d;
  logic [TIME_BITS-1:0] last_pulse_q, last_pulse_d;
  logic                 carried_q, carried_d;
  logic                 settle_pending_q, settle_pending_d;
  logic                 wake_off_q, wake_off_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] gap_el;
  logic [TIME_BITS-1:0] dur_el;
  logic                 gap_over;
  logic                 dur_met;
  logic                 changed;
  logic                 sleep_req;

  assign now_t    = TIME_BITS'(item_i.now_ms);
  assign gap_el   = now_t - last_pulse_q;
  assign dur_el   = now_t - streak_begin_q;
  assign gap_over = CmpW'(gap_el) > CmpW'(cfg_i.step_gap_ms);
  assign dur_met  = CmpW'(dur_el) >= CmpW'(cfg_i.carry_duration_ms);

  always_comb begin
    streak_valid_d   = streak_valid_q;
    streak_begin_d   = streak_begin_q;
    last_pulse_d     = last_pulse_q;
    carried_d        = carried_q;
    settle_pending_d = settle_pending_q;
    wake_off_d       = wake_off_q;
    changed          = 1'b0;
    sleep_req        = 1'b0;
    if (item_i.op == OP_KEY) begin
      streak_valid_d   = 1'b0;
      carried_d        = 1'b0;
      settle_pending_d = 1'b0;
      wake_off_d       = 1'b0;
    end else if (cfg_i.carry_enabled) begin
      case (item_i.op)
        OP_PULSE: begin
          last_pulse_d = now_t;
          if (!streak_valid_q) begin
            streak_valid_d = 1'b1;
            streak_begin_d = now_t;
          end
        end
        OP_CHECK: begin
          if (gap_over) begin
            streak_valid_d = 1'b0;
            if (carried_q) begin
              carried_d = 1'b0;
              changed   = 1'b1;
            end
          end else if (streak_valid_q && dur_met && !carried_q) begin
            carried_d  = 1'b1;
            changed    = 1'b1;
            wake_off_d = 1'b1;
            sleep_req  = 1'b1;
          end
        end
        default: begin
          if (settle_pending_q && cfg_i.still_wake_enabled) begin
            settle_pending_d = 1'b0;
            if (streak_valid_q && !gap_over) begin
              wake_off_d = 1'b1;
              sleep_req  = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_valid_q   <= 1'b0;
      streak_begin_q   <= '0;
      last_pulse_q     <= '0;
      carried_q        <= 1'b0;
      settle_pending_q <= 1'b1;
      wake_off_q       <= 1'b0;
    end else if (fire_i) begin
      streak_valid_q   <= streak_valid_d;
      streak_begin_q   <= streak_begin_d;
      last_pulse_q     <= last_pulse_d;
      carried_q        <= carried_d;
      settle_pending_q <= settle_pending_d;
      wake_off_q       <= wake_off_d;
    end
  end

  assign result_o.carrying      = carried_d;
  assign result_o.state_changed = changed;
  assign result_o.force_sleep   = sleep_req;
  assign result_o.wake_disabled = wake_off_d;

endmodule

`default_nettype wire

// ----- hdl/cmsd_checker.sv -----
// Carry motion streak detector: port-level checker and its bind.
// Watches the top-level ports only; uses cmsd_pkg.
`default_nettype none

module cmsd_checker
  import cmsd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire cmsd_out_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result word dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_sleep_wake_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.force_sleep |-> out_item_o.wake_disabled)
    else $error("sleep forced without wake-up disabled");

  a_carry_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.state_changed && out_item_o.carrying
      |-> out_item_o.force_sleep)
    else $error("carry declared without forcing sleep");

endmodule

bind carry_motion_streak_detector cmsd_checker u_cmsd_checker (.*);

`default_nettype wire

// ----- tb/carry_motion_streak_detector_tb.sv -----
// Testbench for carry_motion_streak_detector: directed event table, then random phases.
// Each result word is checked against the table's expected flags where given, else a local carry-streak predictor.
// Depends on cmsd_pkg and the carry_motion_streak_detector RTL.
`default_nettype none

module carry_motion_streak_detector_tb;
  import cmsd_pkg::*;

  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned Phases        = 8;
  localparam int unsigned WordsPerPhase = 154;
  localparam int unsigned ScriptRows    = 29;

  typedef struct packed {
    logic               is_reg;
    logic [CfgIdxW-1:0] idx;
    cmsd_op_e           op;
    logic [31:0]        val;
    logic               typed;
    cmsd_out_t          res;
  } script_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  cmsd_in_t            in_item     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  cmsd_out_t           out_item;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;

  logic                word_typed  = 1'b0;
  cmsd_out_t           word_res    = '0;

  // predictor copy of registers and streak state
  logic                en_q         = 1'b1;
  logic [DurW-1:0]     dur_q        = CARRY_DUR_RST;
  logic                still_q      = 1'b1;
  logic [GapW-1:0]     gap_q        = STEP_GAP_RST;
  logic                streak_open  = 1'b0;
  logic [31:0]         streak_t0    = '0;
  logic [31:0]         pulse_t      = '0;
  logic                carried      = 1'b0;
  logic                settle_live  = 1'b1;
  logic                wake_blocked = 1'b0;

  cmsd_out_t           carry_flags_due [$];
  string               field_name [4] = '{"carrying", "state_changed", "force_sleep",
                                          "wake_disabled"};

  bit                  steady       = 1'b0;
  int unsigned         ready_left   = 0;
  int unsigned         quiet        = 0;
  int unsigned         errors       = 0;
  int unsigned         words_sent   = 0;
  int unsigned         results_seen = 0;
  int unsigned         reg_writes   = 0;
  int unsigned         onsets       = 0;
  int unsigned         sleeps       = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  carry_motion_streak_detector #(
    .TIME_BITS(32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmsd_out_t judge_event(cmsd_op_e op, logic [31:0] now);
    cmsd_out_t   r;
    logic [31:0] since_pulse;
    logic [31:0] since_begin;
    since_pulse = now - pulse_t;
    since_begin = now - streak_t0;
    r = '0;
    if (op == OP_KEY) begin
      streak_open  = 1'b0;
      carried      = 1'b0;
      settle_live  = 1'b0;
      wake_blocked = 1'b0;
    end else if (en_q) begin
      case (op)
        OP_PULSE: begin
          pulse_t = now;
          if (!streak_open) begin
            streak_open = 1'b1;
            streak_t0   = now;
          end
        end
        OP_CHECK: begin
          if (since_pulse > {16'b0, gap_q}) begin
            streak_open = 1'b0;
            if (carried) begin
              carried         = 1'b0;
              r.state_changed = 1'b1;
            end
          end else if (streak_open && since_begin >= dur_q && !carried) begin
            carried         = 1'b1;
            wake_blocked    = 1'b1;
            r.state_changed = 1'b1;
            r.force_sleep   = 1'b1;
          end
        end
        default: begin
          if (settle_live && still_q) begin
            settle_live = 1'b0;
            if (streak_open && since_pulse <= {16'b0, gap_q}) begin
              wake_blocked  = 1'b1;
              r.force_sleep = 1'b1;
            end
          end
        end
      endcase
    end
    r.carrying      = carried;
    r.wake_disabled = wake_blocked;
    return r;
  endfunction

  function automatic script_row_t evt(cmsd_op_e op, logic [31:0] now);
    script_row_t row;
    row     = '0;
    row.op  = op;
    row.val = now;
    return row;
  endfunction

  function automatic script_row_t evt_x(cmsd_op_e op, logic [31:0] now, logic [3:0] res);
    script_row_t row;
    row       = evt(op, now);
    row.typed = 1'b1;
    row.res   = cmsd_out_t'(res);
    return row;
  endfunction

  function automatic script_row_t reg_wr(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    script_row_t row;
    row        = '0;
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.val    = data;
    return row;
  endfunction

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk_i);
  endtask

  task automatic send_event(input cmsd_op_e op, input logic [31:0] now, input logic typed,
                            input cmsd_out_t res);
    int unsigned idle;
    idle = steady ? 0 : idle_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    in_item    <= '{op: op, now_ms: now};
    word_typed <= typed;
    word_res   <= res;
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain();
    repeat (3) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CARRY_EN:  en_q    = data[0];
      CFG_CARRY_DUR: dur_q   = data;
      CFG_STILL_EN:  still_q = data[0];
      CFG_STEP_GAP:  gap_q   = data[GapW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  always @(posedge clk_i) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      out_ready  <= 1'b1;
      ready_left <= $urandom_range(0, 7);
    end else begin
      out_ready  <= 1'b0;
      ready_left <= idle_len() + 1;
    end
  end

  always @(posedge clk_i) begin
    cmsd_out_t want;
    cmsd_out_t got;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (carry_flags_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %b", $time, out_item);
        end else begin
          want = carry_flags_due.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (want[3-i] !== out_item[3-i]) begin
              errors++;
              $display("%0t: %s expected %b actual %b", $time, field_name[i], want[3-i],
                       out_item[3-i]);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        got = judge_event(in_item.op, in_item.now_ms);
        carry_flags_due.push_back(word_typed ? word_res : got);
        if (got.state_changed && got.carrying) onsets++;
        if (got.force_sleep) sleeps++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else if (quiet == QuietLimit) begin
        $display("stalled for %0d cycles at %0t", quiet, $time);
        $display("carry_motion_streak_detector: mismatch");
        $finish;
      end else begin
        quiet++;
      end
    end
  end

  initial begin
    script_row_t     script [ScriptRows];
    logic [31:0]     t_now;
    logic [31:0]     stamp;
    logic [31:0]     tmp;
    logic            en_v;
    logic            still_v;
    logic [DurW-1:0] dur_v;
    logic [GapW-1:0] gap_v;
    int unsigned     r;
    cmsd_op_e        op;

    script = '{
      evt_x(OP_CHECK,  32'd0,          4'b0000),
      evt_x(OP_CHECK,  32'd2001,       4'b0000),
      evt  (OP_PULSE,  32'd100),
      reg_wr(CFG_STILL_EN, 32'd0),
      evt_x(OP_SETTLE, 32'd2100,       4'b0000),
      reg_wr(CFG_STILL_EN, 32'd1),
      reg_wr(CFG_CARRY_EN, 32'd0),
      evt_x(OP_SETTLE, 32'd2100,       4'b0000),
      reg_wr(CFG_CARRY_EN, 32'd1),
      evt_x(OP_SETTLE, 32'd2100,       4'b0011),
      evt_x(OP_SETTLE, 32'd2100,       4'b0001),
      evt_x(OP_KEY,    32'd0,          4'b0000),
      evt  (OP_PULSE,  32'hFFFF_F000),
      evt  (OP_PULSE,  32'h0000_0700),
      evt  (OP_PULSE,  32'd55904),
      evt_x(OP_CHECK,  32'd55904,      4'b1111),
      evt  (OP_CHECK,  32'd56904),
      evt_x(OP_CHECK,  32'd57905,      4'b0101),
      evt_x(OP_KEY,    32'hFFFF_FFFF,  4'b0000),
      reg_wr(CFG_CARRY_DUR, 32'd0),
      evt  (OP_PULSE,  32'd5),
      evt_x(OP_CHECK,  32'd5,          4'b1111),
      reg_wr(CFG_CARRY_EN, 32'd0),
      evt_x(OP_CHECK,  32'hFFFF_FFFF,  4'b1001),
      evt_x(OP_KEY,    32'd0,          4'b0000),
      reg_wr(CFG_CARRY_EN, 32'd1),
      reg_wr(CfgIdxW'(8'hFF), 32'hFFFF_FFFF),
      evt  (OP_PULSE,  32'd1000),
      evt_x(OP_CHECK,  32'd3001,       4'b0000)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      if (script[k].is_reg) write_reg(script[k].idx, script[k].val);
      else send_event(script[k].op, script[k].val, script[k].typed, script[k].res);
    end

    for (int p = 0; p < Phases; p++) begin
      steady  = (p == 0) || (p == 5);
      en_v    = ($urandom_range(0, 5) != 0);
      still_v = ($urandom_range(0, 1) != 0);
      gap_v   = GapW'($urandom_range(0, 3000));
      dur_v   = $urandom_range(0, 16 * gap_v + 64);
      case (p)
        0: begin
          en_v    = 1'b1;
          still_v = 1'b0;
          gap_v   = '0;
          dur_v   = '0;
        end
        1: begin
          en_v    = 1'b1;
          still_v = 1'b1;
          gap_v   = '1;
          dur_v   = '1;
        end
        3: en_v = 1'b0;
        default: ;
      endcase
      tmp = $urandom;
      tmp[0] = en_v;
      write_reg(CFG_CARRY_EN, tmp);
      write_reg(CFG_CARRY_DUR, dur_v);
      tmp = $urandom;
      tmp[0] = still_v;
      write_reg(CFG_STILL_EN, tmp);
      tmp = $urandom;
      tmp[GapW-1:0] = gap_v;
      write_reg(CFG_STEP_GAP, tmp);
      if ($urandom_range(0, 1) != 0) write_reg(CfgIdxW'($urandom_range(4, 255)), $urandom);

      t_now = (p % 3 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom;
      for (int n = 0; n < WordsPerPhase; n++) begin
        if (n == WordsPerPhase / 2 || $urandom_range(0, 149) == 0) drain();
        if ($urandom_range(0, 99) < 6) begin
          op    = cmsd_op_e'($urandom_range(0, 3));
          stamp = $urandom;
        end else begin
          if ($urandom_range(0, 99) < 85) t_now += $urandom_range(0, gap_v / 2);
          else t_now += $urandom_range(0, gap_v + gap_v / 2 + 2);
          r = $urandom_range(0, 99);
          op = (r < 45) ? OP_PULSE : (r < 92) ? OP_CHECK : (r < 95) ? OP_SETTLE : OP_KEY;
          stamp = t_now;
        end
        send_event(op, stamp, 1'b0, '0);
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    $display("ran %0d event words across %0d phases with %0d register writes", words_sent,
             Phases, reg_writes);
    $display("saw %0d carry onsets and %0d sleep requests, %0d field errors", onsets, sleeps,
             errors);
    if (errors == 0 && carry_flags_due.size() == 0) begin
      $display("carry_motion_streak_detector: match");
    end else begin
      $display("carry_motion_streak_detector: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
